>>> rtl/tpt_pkg.sv
// ---------------------------------------------------------------------------
// Thermopile pixel temperature package
// Shared constants, codes and transaction types of the pixel compensation
// pipeline.
// ---------------------------------------------------------------------------
package tpt_pkg;

   // Number of cells in the divider chain and in each square-root chain.
   localparam int DIV_STEPS  = 113;
   localparam int SQRT_STEPS = 30;

   // 25 degrees Celsius with 8 fraction bits.
   localparam logic [18:0] TA_25      = 19'd6400;
   // 273.15 with 8 fraction bits, rounded.
   localparam logic [18:0] KELVIN_FIX = 19'd69926;
   // 273.15 in Q16.
   localparam logic [30:0] KELVIN_Q16 = 31'd17901158;
   // Saturation value of the quotient magnitude.
   localparam logic [42:0] QUOT_CAP   = {1'b1, 42'd0};

   // Result status codes.
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_NEG  = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_CP_OFFSET   = 3'd0;
   localparam logic [2:0] REG_CP_SLOPE    = 3'd1;
   localparam logic [2:0] REG_CP_SENS     = 3'd2;
   localparam logic [2:0] REG_GRADIENT    = 3'd3;
   localparam logic [2:0] REG_SLOPE_SHIFT = 3'd4;
   localparam logic [2:0] REG_BASE_SENS   = 3'd5;
   localparam logic [2:0] REG_SENS_SHIFTS = 3'd6;
   localparam logic [2:0] REG_EMISSIVITY  = 3'd7;

   localparam logic [15:0] EMISSIVITY_RESET = 16'd32768;

   typedef struct packed {
      logic [7:0]  cp_offset;
      logic [7:0]  cp_slope;
      logic [15:0] cp_sensitivity;
      logic [7:0]  gradient_coeff;
      logic [4:0]  slope_shift;
      logic [15:0] base_sensitivity;
      logic [9:0]  sensitivity_shifts;
      logic [15:0] emissivity;
   } cfg_type;

   // Per-transaction tag that rides along every stage.
   typedef struct packed {
      logic [1:0] status;
      logic [5:0] pos;
   } meta_type;

   // Divider cell state: shifting numerator, partial remainder, quotient.
   typedef struct packed {
      logic [112:0] num;
      logic [63:0]  rem;
      logic [42:0]  quo;
      logic         sat;
      logic [62:0]  dvs;
      logic         neg;
      logic [39:0]  pwr;
   } div_type;

   // Square-root cell state: radicand pairs, remainder, partial root.
   typedef struct packed {
      logic [59:0] rad;
      logic [31:0] rem;
      logic [29:0] root;
   } sqr_type;

endpackage

>>> rtl/tpt_if.sv
// ---------------------------------------------------------------------------
// Thermopile pixel temperature channel interfaces
// Valid/ready channels for pixel requests and temperature responses.
// ---------------------------------------------------------------------------
interface tpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] ir_sample;
   logic signed [7:0]  pixel_offset;
   logic signed [7:0]  pixel_slope;
   logic [7:0]         pixel_sensitivity_delta;
   logic signed [15:0] compensation_sample;
   logic signed [17:0] ambient_temp;
   logic [5:0]         pixel_position;

   modport source (output valid, ir_sample, pixel_offset, pixel_slope,
                   pixel_sensitivity_delta, compensation_sample, ambient_temp,
                   pixel_position, input ready);
   modport sink (input valid, ir_sample, pixel_offset, pixel_slope,
                 pixel_sensitivity_delta, compensation_sample, ambient_temp,
                 pixel_position, output ready);
endinterface

interface tpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] object_temp;
   logic [5:0]         pixel_position_out;
   logic [1:0]         status;

   modport source (output valid, object_temp, pixel_position_out, status,
                   input ready);
   modport sink (input valid, object_temp, pixel_position_out, status,
                 output ready);
endinterface

>>> rtl/thermopile_pixel_temperature.sv
// ---------------------------------------------------------------------------
// Thermopile pixel temperature
// Compensates one raw thermopile pixel sample per transaction and returns
// the object temperature in Celsius with 8 fraction bits.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_bus   in         valid/ready          pixel sample, coefficients, Ta
//  rsp_bus   out        valid/ready          object_temp, position, status
//  csr_*     in         csr_wr_en            register index and write data
//
//  One transaction is accepted per clock while the result register is free
//  or being taken. Each transaction passes through 181 register stages:
//  5 front-end stages, 113 divider cells, a fix-up stage, two chains of
//  30 square-root cells with a reload stage between, and the result
//  register. The divider chain makes up most of the stages.
//  Reset clears all valid flags and loads the register defaults.
//  While a result waits in the output register the whole chain holds.
// ---------------------------------------------------------------------------
module thermopile_pixel_temperature import tpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tpt_req_if.sink     req_bus,
   tpt_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   // Configuration registers. Emissivity sits in the low bits of the struct.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_type'({71'd0, EMISSIVITY_RESET});
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CP_OFFSET:   cfg_ff.cp_offset          <= csr_wr_data[7:0];
            REG_CP_SLOPE:    cfg_ff.cp_slope           <= csr_wr_data[7:0];
            REG_CP_SENS:     cfg_ff.cp_sensitivity     <= csr_wr_data;
            REG_GRADIENT:    cfg_ff.gradient_coeff     <= csr_wr_data[7:0];
            REG_SLOPE_SHIFT: cfg_ff.slope_shift        <= csr_wr_data[4:0];
            REG_BASE_SENS:   cfg_ff.base_sensitivity   <= csr_wr_data;
            REG_SENS_SHIFTS: cfg_ff.sensitivity_shifts <= csr_wr_data[9:0];
            REG_EMISSIVITY:  cfg_ff.emissivity         <= csr_wr_data;
         endcase
      end
   end

   // The chain moves whenever the result register is free or being taken.
   logic out_valid_ff;
   logic adv;

   assign adv           = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // Front end.
   logic     div_v [DIV_STEPS+1];
   div_type  div_d [DIV_STEPS+1];
   meta_type div_m [DIV_STEPS+1];

   tpt_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .adv                     (adv),
      .cfg                     (cfg_ff),
      .in_valid                (req_bus.valid),
      .ir_sample               (req_bus.ir_sample),
      .pixel_offset            (req_bus.pixel_offset),
      .pixel_slope             (req_bus.pixel_slope),
      .pixel_sensitivity_delta (req_bus.pixel_sensitivity_delta),
      .compensation_sample     (req_bus.compensation_sample),
      .ambient_temp            (req_bus.ambient_temp),
      .pixel_position          (req_bus.pixel_position),
      .out_valid               (div_v[0]),
      .out_div                 (div_d[0]),
      .out_meta                (div_m[0])
   );

   // Divider chain.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      tpt_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (div_v[i]),
         .in_div    (div_d[i]),
         .in_meta   (div_m[i]),
         .out_valid (div_v[i+1]),
         .out_div   (div_d[i+1]),
         .out_meta  (div_m[i+1])
      );
   end

   // Signed quotient plus ambient power gives the radicand.
   div_type            dq;
   logic [42:0]        qmag;
   logic signed [43:0] qs;
   logic signed [44:0] rad_sum;
   sqr_type            g_sqr_in, g_sqr_ff;
   meta_type           g_meta_in, g_meta_ff;
   logic               g_valid_ff;

   assign dq      = div_d[DIV_STEPS];
   assign qmag    = dq.sat ? QUOT_CAP : dq.quo;
   assign qs      = dq.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   assign rad_sum = qs + $signed({5'd0, dq.pwr});

   always_comb begin
      g_meta_in = div_m[DIV_STEPS];
      if (div_m[DIV_STEPS].status == STAT_OK && rad_sum[44]) begin
         g_meta_in.status = STAT_NEG;
      end
      g_sqr_in.rad  = {1'b0, rad_sum[42:0], 16'd0};
      g_sqr_in.rem  = 32'd0;
      g_sqr_in.root = 30'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= div_v[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_sqr_ff  <= g_sqr_in;
         g_meta_ff <= g_meta_in;
      end
   end

   // First root: s = isqrt(R * 2^16).
   logic     s1_v [SQRT_STEPS+1];
   sqr_type  s1_d [SQRT_STEPS+1];
   meta_type s1_m [SQRT_STEPS+1];

   assign s1_v[0] = g_valid_ff;
   assign s1_d[0] = g_sqr_ff;
   assign s1_m[0] = g_meta_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq1
      tpt_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (s1_v[i]),
         .in_sqr    (s1_d[i]),
         .in_meta   (s1_m[i]),
         .out_valid (s1_v[i+1]),
         .out_sqr   (s1_d[i+1]),
         .out_meta  (s1_m[i+1])
      );
   end

   // Reload the second chain with s * 2^24.
   sqr_type  h_sqr_in, h_sqr_ff;
   meta_type h_meta_ff;
   logic     h_valid_ff;

   always_comb begin
      h_sqr_in.rad  = {6'd0, s1_d[SQRT_STEPS].root, 24'd0};
      h_sqr_in.rem  = 32'd0;
      h_sqr_in.root = 30'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= s1_v[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_sqr_ff  <= h_sqr_in;
         h_meta_ff <= s1_m[SQRT_STEPS];
      end
   end

   // Second root: Kelvin in Q16.
   logic     s2_v [SQRT_STEPS+1];
   sqr_type  s2_d [SQRT_STEPS+1];
   meta_type s2_m [SQRT_STEPS+1];

   assign s2_v[0] = h_valid_ff;
   assign s2_d[0] = h_sqr_ff;
   assign s2_m[0] = h_meta_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq2
      tpt_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (s2_v[i]),
         .in_sqr    (s2_d[i]),
         .in_meta   (s2_m[i]),
         .out_valid (s2_v[i+1]),
         .out_sqr   (s2_d[i+1]),
         .out_meta  (s2_m[i+1])
      );
   end

   // Convert to Celsius with 8 fraction bits and saturate.
   logic signed [30:0] kel_diff;
   logic signed [30:0] tcs;
   logic [17:0]        temp_in, out_temp_ff;
   logic [5:0]         out_pos_ff;
   logic [1:0]         out_status_ff;
   meta_type           last_meta;

   assign last_meta = s2_m[SQRT_STEPS];
   assign kel_diff  = $signed({1'b0, s2_d[SQRT_STEPS].root}) - $signed(KELVIN_Q16);
   assign tcs       = kel_diff >>> 8;

   always_comb begin
      if (last_meta.status != STAT_OK) begin
         temp_in = 18'd0;
      end else if (tcs > $signed(31'd131071)) begin
         temp_in = 18'h1FFFF;
      end else if (tcs < -$signed(31'd131072)) begin
         temp_in = 18'h20000;
      end else begin
         temp_in = tcs[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s2_v[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_temp_ff   <= temp_in;
         out_pos_ff    <= last_meta.pos;
         out_status_ff <= last_meta.status;
      end
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.object_temp        = $signed(out_temp_ff);
   assign rsp_bus.pixel_position_out = out_pos_ff;
   assign rsp_bus.status             = out_status_ff;

   // A flagged result always carries a zero temperature.
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STAT_OK |-> rsp_bus.object_temp == 18'sd0)
      else $error("flagged result with nonzero temperature");

   // A held result stalls the input side.
   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input accepted while output stalled");

   // No result comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   // A held result stays unchanged.
   a_hold_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> $stable(out_temp_ff) && $stable(out_status_ff))
      else $error("held result changed");

endmodule

>>> rtl/tpt_front.sv
// ---------------------------------------------------------------------------
// Thermopile pixel front end
// Five pipeline stages that form the corrected voltage, the normalized
// sensitivity divisor, the ambient fourth power and the divider numerator.
// ---------------------------------------------------------------------------
module tpt_front import tpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic signed [15:0] ir_sample,
   input  logic signed [7:0]  pixel_offset,
   input  logic signed [7:0]  pixel_slope,
   input  logic [7:0]         pixel_sensitivity_delta,
   input  logic signed [15:0] compensation_sample,
   input  logic signed [17:0] ambient_temp,
   input  logic [5:0]         pixel_position,
   output logic               out_valid,
   output div_type            out_div,
   output meta_type           out_meta
);

   // Stage A: slope products, raw differences, sensitivity numerator.
   logic signed [18:0] dt;
   logic signed [18:0] tak;
   logic signed [24:0] na_lin;
   logic signed [56:0] na_hi;
   logic [56:0]        pd_sh;
   logic [5:0]         pd_amt;

   logic signed [26:0] a_pslope_in, a_cslope_in, a_pslope_ff, a_cslope_ff;
   logic signed [16:0] a_vir0_in, a_vcp0_in, a_vir0_ff, a_vcp0_ff;
   logic signed [56:0] a_na_in, a_na_ff;
   logic [6:0]         a_ea_in, a_ea_ff;
   logic [17:0]        a_tmag_in, a_tmag_ff;
   logic               a_zeps_in, a_zeps_ff;
   logic [5:0]         a_pos_ff;
   logic               a_valid_ff;

   assign dt          = $signed({ambient_temp[17], ambient_temp}) - $signed(TA_25);
   assign a_pslope_in = pixel_slope * dt;
   assign a_cslope_in = $signed(cfg.cp_slope) * dt;
   assign a_vir0_in   = ir_sample - pixel_offset;
   assign a_vcp0_in   = compensation_sample - $signed(cfg.cp_offset);
   assign na_lin      = $signed({4'd0, cfg.base_sensitivity, 5'd0})
                      - $signed(cfg.gradient_coeff) * $signed({1'b0, cfg.cp_sensitivity});
   assign na_hi       = na_lin;
   assign pd_amt      = {1'b0, cfg.sensitivity_shifts[9:5]} + 6'd5;
   assign pd_sh       = {49'd0, pixel_sensitivity_delta} << pd_amt;
   assign a_na_in     = (na_hi <<< cfg.sensitivity_shifts[4:0]) + $signed(pd_sh);
   assign a_ea_in     = 7'd5 + {2'd0, cfg.sensitivity_shifts[9:5]}
                      + {2'd0, cfg.sensitivity_shifts[4:0]};
   assign tak         = $signed({ambient_temp[17], ambient_temp}) + $signed(KELVIN_FIX);
   assign a_tmag_in   = tak[18] ? 18'(-tak) : tak[17:0];
   assign a_zeps_in   = (cfg.emissivity == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_pslope_ff <= a_pslope_in;
         a_cslope_ff <= a_cslope_in;
         a_vir0_ff   <= a_vir0_in;
         a_vcp0_ff   <= a_vcp0_in;
         a_na_ff     <= a_na_in;
         a_ea_ff     <= a_ea_in;
         a_tmag_ff   <= a_tmag_in;
         a_zeps_ff   <= a_zeps_in;
         a_pos_ff    <= pixel_position;
      end
   end

   // Stage B: Q16 voltages with the slope term, divisor magnitude, TaK squared.
   logic [5:0]         shs;
   logic signed [43:0] b_vcp_in, b_vir_in, b_vcp_ff, b_vir_ff;
   logic [55:0]        b_nmag_in, b_nmag_ff;
   logic               b_nneg_ff, b_nzero_in, b_nzero_ff, b_zeps_ff;
   logic [35:0]        b_tsq_in, b_tsq_ff;
   logic [6:0]         b_ea_ff;
   logic [5:0]         b_pos_ff;
   logic               b_valid_ff;

   assign shs        = 6'd8 + {1'b0, cfg.slope_shift};
   assign b_vcp_in   = $signed({a_vcp0_ff, 16'd0}) - ($signed({a_cslope_ff, 16'd0}) >>> shs);
   assign b_vir_in   = $signed({a_vir0_ff, 16'd0}) - ($signed({a_pslope_ff, 16'd0}) >>> shs);
   assign b_nmag_in  = a_na_ff[56] ? 56'(-a_na_ff) : a_na_ff[55:0];
   assign b_nzero_in = (a_na_ff == 57'sd0);
   assign b_tsq_in   = a_tmag_ff * a_tmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_vcp_ff   <= b_vcp_in;
         b_vir_ff   <= b_vir_in;
         b_nmag_ff  <= b_nmag_in;
         b_nneg_ff  <= a_na_ff[56];
         b_nzero_ff <= b_nzero_in;
         b_zeps_ff  <= a_zeps_ff;
         b_tsq_ff   <= b_tsq_in;
         b_ea_ff    <= a_ea_ff;
         b_pos_ff   <= a_pos_ff;
      end
   end

   // Stage C: gradient product, divisor normalization below 2^47, TaK^4.
   logic [3:0]         nsh;
   logic signed [51:0] c_gv_in, c_gv_ff;
   logic [46:0]        c_mag_in, c_mag_ff;
   logic [6:0]         c_ea_in, c_ea_ff;
   logic [55:0]        c_psq_in, c_psq_ff;
   logic signed [43:0] c_vir_ff;
   logic               c_nneg_ff, c_zero_ff;
   logic [5:0]         c_pos_ff;
   logic               c_valid_ff;

   always_comb begin
      nsh = 4'd0;
      for (int i = 47; i < 56; i++) begin
         if (b_nmag_ff[i]) begin
            nsh = 4'(i - 46);
         end
      end
   end

   assign c_gv_in  = $signed(cfg.gradient_coeff) * b_vcp_ff;
   assign c_mag_in = 47'(b_nmag_ff >> nsh);
   assign c_ea_in  = b_ea_ff - {3'd0, nsh};
   assign c_psq_in = b_tsq_ff[35:8] * b_tsq_ff[35:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_gv_ff   <= c_gv_in;
         c_mag_ff  <= c_mag_in;
         c_ea_ff   <= c_ea_in;
         c_psq_ff  <= c_psq_in;
         c_vir_ff  <= b_vir_ff;
         c_nneg_ff <= b_nneg_ff;
         c_zero_ff <= b_zeps_ff | b_nzero_ff;
         c_pos_ff  <= b_pos_ff;
      end
   end

   // Stage D: final voltage, full divisor, ambient power term, result sign.
   logic signed [47:0] d_v_in, d_v_ff;
   logic [62:0]        d_dvs_in, d_dvs_ff;
   logic               d_neg_ff;
   logic [39:0]        d_pwr_ff;
   logic [6:0]         d_ea_ff;
   meta_type           d_meta_in, d_meta_ff;
   logic               d_valid_ff;

   assign d_v_in   = 48'(c_vir_ff - (c_gv_ff >>> 5));
   assign d_dvs_in = cfg.emissivity * c_mag_ff;
   always_comb begin
      d_meta_in.pos    = c_pos_ff;
      d_meta_in.status = c_zero_ff ? STAT_ZERO : STAT_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_v_ff    <= d_v_in;
         d_dvs_ff  <= d_dvs_in;
         d_neg_ff  <= d_v_in[47] ^ c_nneg_ff;
         d_pwr_ff  <= c_psq_ff[55:16];
         d_ea_ff   <= c_ea_ff;
         d_meta_ff <= d_meta_in;
      end
   end

   // Stage E: scaled numerator, loaded into the first divider cell.
   logic [46:0] amag;
   logic [6:0]  esh;
   div_type     e_div_in, e_div_ff;
   meta_type    e_meta_ff;
   logic        e_valid_ff;

   assign amag = d_v_ff[47] ? 47'(-d_v_ff) : d_v_ff[46:0];
   assign esh  = d_ea_ff - 7'd1;

   always_comb begin
      e_div_in.num = {66'd0, amag} << esh;
      e_div_in.rem = 64'd0;
      e_div_in.quo = 43'd0;
      e_div_in.sat = 1'b0;
      e_div_in.dvs = d_dvs_ff;
      e_div_in.neg = d_neg_ff;
      e_div_in.pwr = d_pwr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_div_ff  <= e_div_in;
         e_meta_ff <= d_meta_ff;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_div   = e_div_ff;
   assign out_meta  = e_meta_ff;

endmodule

>>> rtl/tpt_div_cell.sv
// ---------------------------------------------------------------------------
// Thermopile divider cell
// One restoring long-division step: takes one numerator bit and yields one
// quotient bit, with a sticky flag once the quotient reaches 2^42.
// ---------------------------------------------------------------------------
module tpt_div_cell import tpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  div_type  in_div,
   input  meta_type in_meta,
   output logic     out_valid,
   output div_type  out_div,
   output meta_type out_meta
);

   logic [63:0] shifted;
   logic [63:0] dvs_ext;
   logic        take;
   div_type     div_in, div_ff;
   meta_type    meta_ff;
   logic        valid_ff;

   // Shift in the next numerator bit and try the subtraction.
   always_comb begin
      shifted      = {in_div.rem[62:0], in_div.num[112]};
      dvs_ext      = {1'b0, in_div.dvs};
      take         = (shifted >= dvs_ext);
      div_in       = in_div;
      div_in.num   = {in_div.num[111:0], 1'b0};
      div_in.rem   = take ? (shifted - dvs_ext) : shifted;
      div_in.quo   = {in_div.quo[41:0], take};
      div_in.sat   = in_div.sat | in_div.quo[41];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff  <= div_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_meta  = meta_ff;

endmodule

>>> rtl/tpt_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Thermopile square-root cell
// One digit-by-digit square-root step: takes two radicand bits and yields
// one root bit.
// ---------------------------------------------------------------------------
module tpt_sqrt_cell import tpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  sqr_type  in_sqr,
   input  meta_type in_meta,
   output logic     out_valid,
   output sqr_type  out_sqr,
   output meta_type out_meta
);

   logic [33:0] cur;
   logic [33:0] trial;
   logic        take;
   sqr_type     sqr_in, sqr_ff;
   meta_type    meta_ff;
   logic        valid_ff;

   // Bring down the next bit pair and compare against 4*root + 1.
   always_comb begin
      cur         = {in_sqr.rem, in_sqr.rad[59:58]};
      trial       = {2'd0, in_sqr.root, 2'b01};
      take        = (cur >= trial);
      sqr_in.rad  = {in_sqr.rad[57:0], 2'b00};
      sqr_in.rem  = take ? 32'(cur - trial) : cur[31:0];
      sqr_in.root = {in_sqr.root[28:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqr_ff  <= sqr_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_sqr   = sqr_ff;
   assign out_meta  = meta_ff;

endmodule
